>>> hw/rtl/tpq_pkg.sv
`default_nettype none

package tpq_pkg;

  localparam int unsigned IdW  = 6;
  localparam int unsigned LvlW = 2;
  localparam int unsigned StW  = 2;
  localparam int unsigned NumLvl = 3;

  // request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // queue levels, index into the per-level state
  localparam logic [LvlW-1:0] LVL_LOW  = 2'd0;
  localparam logic [LvlW-1:0] LVL_MED  = 2'd1;
  localparam logic [LvlW-1:0] LVL_HIGH = 2'd2;
  localparam logic [LvlW-1:0] LVL_SAT  = 2'd3;

  // result status codes
  localparam logic [StW-1:0] ST_DONE  = 2'd0;
  localparam logic [StW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StW-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic            req_type;
    logic [IdW-1:0]  task_id;
    logic [LvlW-1:0] priority_level;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0] popped_id;
    logic [StW-1:0] status;
    logic           any_waiting;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic exec;
    logic load;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/tpq_ctrl.sv
`default_nettype none

module tpq_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output tpq_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign cmd_o.exec = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.load = (state_q == S_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (out_ready_i) out_valid_q <= 1'b0;
          if (in_valid_i) state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tpq_datapath.sv
`default_nettype none

module tpq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  tpq_pkg::ctrl_cmd_t  cmd_i,
  input  tpq_pkg::in_item_t   in_item_i,
  output tpq_pkg::out_item_t  out_item_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [PtrW-1:0] heads_q  [tpq_pkg::NumLvl];
  logic [PtrW-1:0] heads_d  [tpq_pkg::NumLvl];
  logic [PtrW-1:0] tails_q  [tpq_pkg::NumLvl];
  logic [PtrW-1:0] tails_d  [tpq_pkg::NumLvl];
  logic [CntW-1:0] counts_q [tpq_pkg::NumLvl];
  logic [CntW-1:0] counts_d [tpq_pkg::NumLvl];

  logic [tpq_pkg::IdW-1:0]  rd_q [tpq_pkg::NumLvl];
  logic [tpq_pkg::LvlW-1:0] push_lvl;
  logic [tpq_pkg::LvlW-1:0] pop_lvl;
  logic [tpq_pkg::LvlW-1:0] sel_q;
  logic [tpq_pkg::StW-1:0]  status_d;
  logic [tpq_pkg::StW-1:0]  status_q;
  logic                     pop_ok_q;
  logic                     is_push;
  logic                     is_pop;
  logic                     push_full;
  logic                     any_held;
  logic                     push_ok;
  logic                     pop_ok;
  tpq_pkg::out_item_t       out_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign is_push  = (in_item_i.req_type == tpq_pkg::REQ_PUSH);
  assign is_pop   = (in_item_i.req_type == tpq_pkg::REQ_POP);
  // code three saturates to the high queue
  assign push_lvl = (in_item_i.priority_level == tpq_pkg::LVL_SAT) ? tpq_pkg::LVL_HIGH
                                                                   : in_item_i.priority_level;
  assign push_full = (counts_q[push_lvl] == CntW'(QUEUE_DEPTH));
  assign any_held  = (counts_q[0] != '0) || (counts_q[1] != '0) || (counts_q[2] != '0);
  assign push_ok   = cmd_i.exec && is_push && !push_full;
  assign pop_ok    = cmd_i.exec && is_pop && any_held;

  // strict priority pick of the queue to pop
  always_comb begin
    priority if (counts_q[tpq_pkg::LVL_HIGH] != '0) pop_lvl = tpq_pkg::LVL_HIGH;
    else if (counts_q[tpq_pkg::LVL_MED] != '0)     pop_lvl = tpq_pkg::LVL_MED;
    else                                           pop_lvl = tpq_pkg::LVL_LOW;
  end

  always_comb begin
    if (is_push && push_full)      status_d = tpq_pkg::ST_FULL;
    else if (is_pop && !any_held)  status_d = tpq_pkg::ST_EMPTY;
    else                           status_d = tpq_pkg::ST_DONE;
  end

  always_comb begin
    for (int l = 0; l < tpq_pkg::NumLvl; l++) begin
      heads_d[l]  = heads_q[l];
      tails_d[l]  = tails_q[l];
      counts_d[l] = counts_q[l];
    end
    if (push_ok) begin
      tails_d[push_lvl]  = next_ptr(tails_q[push_lvl]);
      counts_d[push_lvl] = counts_q[push_lvl] + 1'b1;
    end
    if (pop_ok) begin
      heads_d[pop_lvl]  = next_ptr(heads_q[pop_lvl]);
      counts_d[pop_lvl] = counts_q[pop_lvl] - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < tpq_pkg::NumLvl; l++) begin
        heads_q[l]  <= '0;
        tails_q[l]  <= '0;
        counts_q[l] <= '0;
      end
    end else begin
      for (int l = 0; l < tpq_pkg::NumLvl; l++) begin
        heads_q[l]  <= heads_d[l];
        tails_q[l]  <= tails_d[l];
        counts_q[l] <= counts_d[l];
      end
    end
  end

  // one entry store per level, one write and one registered read each
  for (genvar g = 0; g < tpq_pkg::NumLvl; g++) begin : g_store
    logic [tpq_pkg::IdW-1:0] mem [QUEUE_DEPTH];

    always_ff @(posedge clk_i) begin
      if (push_ok && (push_lvl == tpq_pkg::LvlW'(g))) begin
        mem[tails_q[g]] <= in_item_i.task_id;
      end
      if (cmd_i.exec) begin
        rd_q[g] <= mem[heads_q[g]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      sel_q    <= pop_lvl;
      pop_ok_q <= is_pop && any_held;
      status_q <= status_d;
    end
    if (cmd_i.load) begin
      out_q.popped_id   <= pop_ok_q ? rd_q[sel_q] : '0;
      out_q.status      <= status_q;
      out_q.any_waiting <= any_held;
    end
  end

  assign out_item_o = out_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (counts_q[0] <= CntW'(QUEUE_DEPTH)) && (counts_q[1] <= CntW'(QUEUE_DEPTH)) &&
    (counts_q[2] <= CntW'(QUEUE_DEPTH)))
    else $error("queue count above depth");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && is_push && push_full) |=>
    ($stable(counts_q[0]) && $stable(counts_q[1]) && $stable(counts_q[2]) &&
     status_q == tpq_pkg::ST_FULL))
    else $error("refused push changed queue state");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && is_pop && !any_held) |=> (!pop_ok_q && status_q == tpq_pkg::ST_EMPTY))
    else $error("pop on empty queues not flagged");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/three_level_priority_queue.sv
// three-level strict priority queue of 6-bit task ids
// input channel: in_valid_i / in_ready_o carry one request item (in_item_i):
//   push appends task_id to the queue picked by priority_level (0 low, 1 medium,
//   2 high, 3 taken as high); pop removes the head of the highest non-empty queue
// output channel: out_valid_o / out_ready_i carry one result item per request
//   (out_item_o): popped id or zero, status (done, all empty, queue full) and
//   whether any queue still holds an entry
// result: a request is taken into S_DONE, where the store read is registered, and
//   is then loaded into the output register once that register is free
// requests: the block takes no new request until the last one is loaded into the
//   output register; the entry stores have a registered read port, so a request
//   first updates pointers and reads the store and then loads the output register
// reset: all queues empty, output register not valid; no clearing pass, store
//   read data is only used for pops, which read entries that were written
// stall: a held result stays in the output register while one more request is
//   taken and worked; the block then waits with in_ready_o low until it drains
`default_nettype none

module three_level_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  tpq_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output tpq_pkg::out_item_t  out_item_o
);

  // commands from the sequencer to the queue datapath
  tpq_pkg::ctrl_cmd_t cmd;

  tpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // pointers, counts, entry stores and the output register
  tpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
